FILE: design/mtfpc_pkg.sv
// ----------------------------------------------------------------------------
// Move-to-front predictive codec package
// Shared constants and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package mtfpc_pkg;

	localparam int SYM_BITS  = 8;
	localparam int SYMS      = 256;
	localparam int HIT_BONUS = 4;

	// configuration register indexes
	localparam logic CFG_ENCODE_MODE    = 1'b0;
	localparam logic CFG_PREDICT_ENABLE = 1'b1;

	typedef struct packed {
		logic load;    // input transaction accepted: lookup and first move
		logic finish;  // prediction step done: update tables, emit result
	} cmd_t;

endpackage

FILE: design/mtfpc_ctrl.sv
// ----------------------------------------------------------------------------
// Move-to-front predictive codec controller
// Two-state sequencer and output valid tracking.
// ----------------------------------------------------------------------------
module mtfpc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mtfpc_pkg::cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_PRED = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.finish = (state_q == S_PRED) && (!out_valid_q || out_ready);

	// advance between lookup and prediction steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_PRED;
				S_PRED: if (cmd.finish) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: design/mtfpc_datapath.sv
// ----------------------------------------------------------------------------
// Move-to-front predictive codec datapath
// Symbol cell list with a shared search and move unit, successor and weight
// tables, configuration registers and the output register.
// ----------------------------------------------------------------------------
module mtfpc_datapath #(
	parameter int WEIGHT_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mtfpc_pkg::cmd_t cmd,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic            cfg_data,
	input  logic [7:0]      in_byte,
	input  logic            end_of_buffer,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	localparam int SB = mtfpc_pkg::SYM_BITS;
	localparam int N  = mtfpc_pkg::SYMS;
	localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

	logic [SB-1:0] list_q [N];
	logic          vld_q  [N];
	logic [SB-1:0] gmem   [N];
	logic [WEIGHT_BITS-1:0] wmem [N];

	logic encode_q, predict_q;
	logic [SB-1:0] prev_q, pv_q, cur_q, res_q, out_byte_q;
	logic last_q, pred_item_q, out_last_q;
	logic [SB-1:0] rg_pv_q, rg_cur_q;
	logic [WEIGHT_BITS-1:0] rw_pv_q, rw_cur_q;

	logic [SB-1:0] key, pos, mv_pos, mv_sym, sym_c;
	logic          mv_en;
	logic [SB-1:0] g_pv, ng, gc;
	logic [WEIGHT_BITS-1:0] w_pv, nw, wc, w_sh;
	logic [WEIGHT_BITS:0]   w_sum;
	logic hit, move2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_q  <= 1'b1;
			predict_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtfpc_pkg::CFG_ENCODE_MODE:    encode_q  <= cfg_data;
				mtfpc_pkg::CFG_PREDICT_ENABLE: predict_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// search the cells for a symbol; matches are one-hot in a permutation
	assign key = cmd.load ? in_byte : gc;
	always_comb begin
		pos = '0;
		for (int k = 0; k < N; k++) begin
			if (list_q[k] == key) pos = pos | SB'(k);
		end
	end

	assign sym_c = encode_q ? in_byte : list_q[in_byte];

	// select the move: item symbol on load, predicted successor on finish when prediction is on and its weight exceeds one
	always_comb begin
		if (cmd.load) begin
			mv_en  = 1'b1;
			mv_pos = encode_q ? pos : in_byte;
			mv_sym = sym_c;
		end else begin
			mv_en  = cmd.finish && move2;
			mv_pos = pos;
			mv_sym = gc;
		end
	end

	// shift the cell list and reinitialize after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) list_q[k] <= SB'(k);
		end else if (cmd.finish && last_q) begin
			for (int k = 0; k < N; k++) list_q[k] <= SB'(k);
		end else if (mv_en) begin
			list_q[0] <= mv_sym;
			for (int k = 1; k < N; k++) begin
				if (SB'(k) <= mv_pos) list_q[k] <= list_q[k-1];
			end
		end
	end

	// latch the item and read both table entries
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pv_q        <= prev_q;
			cur_q       <= sym_c;
			res_q       <= encode_q ? pos : sym_c;
			last_q      <= end_of_buffer;
			pred_item_q <= predict_q;
			rg_pv_q     <= gmem[prev_q];
			rw_pv_q     <= wmem[prev_q];
			rg_cur_q    <= gmem[sym_c];
			rw_cur_q    <= wmem[sym_c];
		end
	end

	// update the previous symbol's guess and weight
	always_comb begin
		g_pv  = vld_q[pv_q] ? rg_pv_q : pv_q;
		w_pv  = vld_q[pv_q] ? rw_pv_q : '0;
		hit   = (g_pv == cur_q);
		w_sum = {1'b0, w_pv} + (WEIGHT_BITS+1)'(mtfpc_pkg::HIT_BONUS);
		w_sh  = w_pv >> 1;
		if (hit) begin
			ng = g_pv;
			nw = w_sum[WEIGHT_BITS] ? WMAX : w_sum[WEIGHT_BITS-1:0];
		end else if (w_sh == '0) begin
			ng = cur_q;
			nw = WEIGHT_BITS'(1);
		end else begin
			ng = g_pv;
			nw = w_sh;
		end
		// forward the fresh entry when the symbol repeats
		if (cur_q == pv_q) begin
			gc = ng;
			wc = nw;
		end else begin
			gc = vld_q[cur_q] ? rg_cur_q : cur_q;
			wc = vld_q[cur_q] ? rw_cur_q : '0;
		end
		move2 = pred_item_q && (wc > WEIGHT_BITS'(1));
	end

	// write the tables
	always_ff @(posedge clk) begin
		if (cmd.finish && pred_item_q) begin
			gmem[pv_q] <= ng;
			wmem[pv_q] <= nw;
		end
	end

	// track written entries and the previous symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
			prev_q <= '0;
		end else if (cmd.finish) begin
			if (last_q) begin
				for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
				prev_q <= '0;
			end else if (pred_item_q) begin
				vld_q[pv_q] <= 1'b1;
				prev_q      <= cur_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_byte_q <= res_q;
			out_last_q <= last_q;
		end
	end

	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule

FILE: design/move_to_front_predictive_codec.sv
// ----------------------------------------------------------------------------
// Move-to-front predictive codec
// Byte-wise move-to-front encoder/decoder with successor prediction.
//
//  channel  | direction | signals
//  ---------+-----------+----------------------------------------------
//  input    | in        | in_valid, in_ready, in_byte, end_of_buffer
//  output   | out       | out_valid, out_ready, out_byte, out_last
//  config   | in        | cfg_we, cfg_index, cfg_data
//
// Each transaction has two steps: the list lookup and move, then the table
// update and predicted-successor move, both through one shared search and
// shift unit over the 256-cell list.
// Reset and the last item of a buffer restore the list directly, and the
// guesses and weights at once through per-entry valid bits; there is no clearing pass.
// A waiting result stalls the second step, and with it the input.
// ----------------------------------------------------------------------------
module move_to_front_predictive_codec #(
	parameter int WEIGHT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_buffer,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	mtfpc_pkg::cmd_t cmd;

	mtfpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mtfpc_datapath #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_byte       (in_byte),
		.end_of_buffer (end_of_buffer),
		.out_byte      (out_byte),
		.out_last      (out_last)
	);

endmodule
